@@ hw/rtl/wmd_pkg.sv @@
// ----------------------------------------------------------------------------
// wmd_pkg: shared definitions for the window mean and deviation block
// Field widths, parameter defaults, register reset values, register indexes
// and the status record that the serial arithmetic units report.
// ----------------------------------------------------------------------------
`default_nettype none

package wmd_pkg;

  // Fixed port widths
  localparam int IN_W      = 16;  // sample field
  localparam int OUT_W     = 16;  // hour_average, day_mean, day_sd
  localparam int IDX_W     = 5;   // day_index, hour_index
  localparam int CFG_W     = 5;   // configuration data
  localparam int CFG_IDX_W = 2;   // configuration register index

  // Parameter defaults
  localparam int DEF_MAX_SAMPLES_PER_HOUR = 16;
  localparam int DEF_MAX_HOURS_PER_DAY    = 24;
  localparam int DEF_SAMPLE_BITS          = 16;

  // Register reset values
  localparam int RST_SAMPLES_PER_HOUR = 4;
  localparam int RST_HOURS_PER_DAY    = 14;
  localparam int RST_DAYS_PER_PERIOD  = 30;

  // Highest value a day counter compare may see
  localparam int DAY_CAP = 31;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLES_PER_HOUR = 2'd0,
    REG_HOURS_PER_DAY    = 2'd1,
    REG_DAYS_PER_PERIOD  = 2'd2
  } cfg_reg_t;

  // Status of a serial arithmetic unit
  typedef struct packed {
    logic busy;  // operation in progress
    logic done;  // one-cycle strobe, result valid
  } unit_stat_t;

endpackage : wmd_pkg

`default_nettype wire

@@ hw/rtl/wmd_mul.sv @@
// ----------------------------------------------------------------------------
// wmd_mul: serial shift-add multiplier
// Unsigned product, one multiplier bit per cycle. The multiplier operand
// shifts right and the run ends as soon as its remaining bits are zero.
// ----------------------------------------------------------------------------
`default_nettype none

module wmd_mul #(
  parameter int A_W = 40,
  parameter int B_W = 26,
  parameter int P_W = 52
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [A_W-1:0]     a,
  input  wire logic [B_W-1:0]     b,
  output wmd_pkg::unit_stat_t     stat,
  output logic      [P_W-1:0]     prod
);

  logic             busy_r;
  logic             done_r;
  logic [P_W-1:0]   acc_r;
  logic [P_W-1:0]   mcand_r;
  logic [B_W-1:0]   mplier_r;

  // Control: run until the multiplier is exhausted
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (mplier_r == '0)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Datapath: add the shifted multiplicand where the low multiplier bit is set
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r    <= '0;
      mcand_r  <= P_W'(a);
      mplier_r <= b;
    end else if (busy_r && (mplier_r != '0)) begin
      if (mplier_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r  <= mcand_r << 1;
      mplier_r <= mplier_r >> 1;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign prod      = acc_r;

endmodule : wmd_mul

`default_nettype wire

@@ hw/rtl/wmd_div.sv @@
// ----------------------------------------------------------------------------
// wmd_div: serial restoring divider
// Unsigned quotient, one bit per cycle over the full dividend width.
// The divisor must be nonzero.
// ----------------------------------------------------------------------------
`default_nettype none

module wmd_div #(
  parameter int DV_W = 26,
  parameter int DS_W = 9
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [DV_W-1:0]    dividend,
  input  wire logic [DS_W-1:0]    divisor,
  output wmd_pkg::unit_stat_t     stat,
  output logic      [DV_W-1:0]    quotient
);

  localparam int CW = (DV_W > 1) ? $clog2(DV_W) : 1;
  localparam logic [CW-1:0] LAST = CW'(DV_W - 1);

  logic              busy_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic [DV_W-1:0]   quo_r;
  logic [DS_W-1:0]   rem_r;
  logic [DS_W-1:0]   den_r;

  logic [DS_W:0]     shifted;
  logic              ge;
  logic [DS_W:0]     diff;

  // One restoring step: bring down the next dividend bit, try a subtract
  always_comb begin
    shifted = {rem_r, quo_r[DV_W-1]};
    ge      = shifted >= {1'b0, den_r};
    diff    = shifted - {1'b0, den_r};
  end

  // Control: fixed number of steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == LAST)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Datapath: dividend shifts out as quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
      cnt_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[DV_W-2:0], ge};
      rem_r <= ge ? diff[DS_W-1:0] : shifted[DS_W-1:0];
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule : wmd_div

`default_nettype wire

@@ hw/rtl/window_mean_and_deviation.sv @@
// Sequence: a sample that closes no hour is squared by the serial multiplier
//   one bit per cycle; an hour end adds a pass through the restoring divider.
// A day end then adds two long multiplies, a 2-bits-per-cycle square root and
//   two more divides before the result is handed to the output register.
// Throughput: one request at a time; the next is taken once the FSM is back in idle.
// Reset: synchronous active-low; registers return to 4/14/30, all sums and counters clear.
// ----------------------------------------------------------------------------
// window_mean_and_deviation: hour averages and day mean / standard deviation
// Accumulates samples into hour and day sums, then derives the hour average,
// the day mean and the population deviation with shared serial units.
// ----------------------------------------------------------------------------
`default_nettype none

module window_mean_and_deviation #(
  parameter int MAX_SAMPLES_PER_HOUR = wmd_pkg::DEF_MAX_SAMPLES_PER_HOUR,
  parameter int MAX_HOURS_PER_DAY    = wmd_pkg::DEF_MAX_HOURS_PER_DAY,
  parameter int SAMPLE_BITS          = wmd_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // sample channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [wmd_pkg::IN_W-1:0]   in_sample,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic        [wmd_pkg::IDX_W-1:0]       out_day_index,
  output logic        [wmd_pkg::IDX_W-1:0]       out_hour_index,
  output logic signed [wmd_pkg::OUT_W-1:0]       out_hour_average,
  output logic                                   out_day_end,
  output logic signed [wmd_pkg::OUT_W-1:0]       out_day_mean,
  output logic        [wmd_pkg::OUT_W-1:0]       out_day_sd,
  // configuration write channel
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic   [wmd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic   [wmd_pkg::CFG_W-1:0]       cfg_data
);

  localparam int IN_W  = wmd_pkg::IN_W;
  localparam int OUT_W = wmd_pkg::OUT_W;
  localparam int IDX_W = wmd_pkg::IDX_W;
  localparam int CFG_W = wmd_pkg::CFG_W;
  localparam int SB    = SAMPLE_BITS;

  // Effective register ranges (a 5-bit register never exceeds 31)
  localparam int SPH_CAP = (MAX_SAMPLES_PER_HOUR < 31) ? MAX_SAMPLES_PER_HOUR : 31;
  localparam int HPD_CAP = (MAX_HOURS_PER_DAY < 31) ? MAX_HOURS_PER_DAY : 31;
  localparam int N_MAX   = SPH_CAP * HPD_CAP;

  localparam int CNT_W  = $clog2(SPH_CAP + 1);
  localparam int HC_W   = $clog2(HPD_CAP + 1);
  localparam int NW     = $clog2(N_MAX + 1);
  localparam int HACC_W = SB + $clog2(SPH_CAP) + 1;
  localparam int DACC_W = SB + $clog2(N_MAX) + 1;
  localparam int SQ_W   = 2 * SB - 1 + $clog2(N_MAX);

  // Serial unit sizes
  localparam int P_W   = (SQ_W + NW > 2 * DACC_W) ? SQ_W + NW : 2 * DACC_W;
  localparam int A_W   = (SQ_W > DACC_W) ? SQ_W : DACC_W;
  localparam int B_W   = (DACC_W > NW) ? DACC_W : NW;
  localparam int ISQ_W = (P_W + 1) / 2;
  localparam int D_W   = 2 * ISQ_W;
  localparam int SC_W  = $clog2(ISQ_W);
  localparam int DV_W  = (DACC_W > ISQ_W) ? DACC_W : ISQ_W;
  localparam int DS_W  = NW;
  localparam int QX_W  = (DV_W > OUT_W + 1) ? DV_W : OUT_W + 1;

  // Saturation limits
  localparam logic [QX_W-1:0] POS_LIM = QX_W'(2 ** (OUT_W - 1) - 1);
  localparam logic [QX_W-1:0] NEG_LIM = QX_W'(2 ** (OUT_W - 1));
  localparam logic [QX_W-1:0] UNS_LIM = QX_W'(2 ** OUT_W - 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_HDIV,
    ST_NSQ,
    ST_SMSQ,
    ST_SQRT,
    ST_SDDIV,
    ST_MDIV,
    ST_OUT
  } state_t;

  state_t                     state_r;

  // configuration
  logic [CFG_W-1:0]           reg_sph_r;
  logic [CFG_W-1:0]           reg_hpd_r;
  logic [CFG_W-1:0]           reg_dpp_r;
  logic [CNT_W-1:0]           sph_eff;
  logic [HC_W-1:0]            hpd_eff;
  logic [CFG_W-1:0]           dpp_eff;
  logic [NW-1:0]              n_eff;

  // running state
  logic signed [HACC_W-1:0]   hacc_r;
  logic signed [DACC_W-1:0]   dacc_r;
  logic [SQ_W-1:0]            sqacc_r;
  logic [CNT_W-1:0]           samp_cnt_r;
  logic [HC_W-1:0]            hour_cnt_r;
  logic [CFG_W-1:0]           day_cnt_r;
  logic                       hour_end_r;

  // sample decode
  logic signed [SB-1:0]       samp_v;
  logic [SB-1:0]              mag;
  logic [CNT_W-1:0]           cnt_nxt;
  logic [HACC_W-1:0]          habs;
  logic [DACC_W-1:0]          dabs;
  logic [HC_W:0]              hour_inc;
  logic                       day_end_w;
  logic [CFG_W:0]             day_inc;
  logic                       day_wrap;

  // serial units
  logic                       mul_start_r;
  logic [A_W-1:0]             mul_a_r;
  logic [B_W-1:0]             mul_b_r;
  logic [P_W-1:0]             mul_prod;
  wmd_pkg::unit_stat_t        mul_stat;
  logic                       div_start_r;
  logic [DV_W-1:0]            div_dvd_r;
  logic [DS_W-1:0]            div_dvs_r;
  logic                       div_neg_r;
  logic [DV_W-1:0]            div_quo;
  wmd_pkg::unit_stat_t        div_stat;
  logic [P_W-1:0]             nsq_r;

  // square root
  logic [D_W-1:0]             sq_d_r;
  logic [ISQ_W+1:0]           sq_rem_r;
  logic [ISQ_W-1:0]           sq_root_r;
  logic [SC_W-1:0]            sq_cnt_r;
  logic [ISQ_W+1:0]           rem_sh;
  logic [ISQ_W+1:0]           trial;
  logic                       sq_ge;
  logic [ISQ_W+1:0]           sq_rem_nxt;
  logic [ISQ_W-1:0]           sq_root_nxt;

  // staged result and output register
  logic [IDX_W-1:0]           res_day_r;
  logic [IDX_W-1:0]           res_hour_r;
  logic [OUT_W-1:0]           res_havg_r;
  logic                       res_dend_r;
  logic [OUT_W-1:0]           res_dmean_r;
  logic [OUT_W-1:0]           res_dsd_r;
  logic                       out_valid_r;
  logic [IDX_W-1:0]           out_day_r;
  logic [IDX_W-1:0]           out_hour_r;
  logic [OUT_W-1:0]           out_havg_r;
  logic                       out_dend_r;
  logic [OUT_W-1:0]           out_dmean_r;
  logic [OUT_W-1:0]           out_dsd_r;

  // Clamp a signed quotient given as magnitude and sign
  function automatic logic [OUT_W-1:0] sat_s(input logic [QX_W-1:0] m, input logic neg);
    logic [QX_W-1:0] nm;
    nm = -m;
    if (neg) begin
      return (m > NEG_LIM) ? OUT_W'(NEG_LIM) : OUT_W'(nm);
    end
    return (m > POS_LIM) ? OUT_W'(POS_LIM) : OUT_W'(m);
  endfunction

  // Clamp an unsigned quotient
  function automatic logic [OUT_W-1:0] sat_u(input logic [QX_W-1:0] m);
    return (m > UNS_LIM) ? OUT_W'(UNS_LIM) : OUT_W'(m);
  endfunction

  // Take the low SAMPLE_BITS of the sample, or zero-extend it when SAMPLE_BITS is wider
  if (SB <= IN_W) begin : g_narrow
    assign samp_v = in_sample[SB-1:0];
  end else begin : g_wide
    assign samp_v = {{(SB - IN_W){1'b0}}, in_sample};
  end

  // Effective settings: zero acts as one, large values clamp
  always_comb begin
    if (reg_sph_r == '0) begin
      sph_eff = CNT_W'(1);
    end else if (reg_sph_r > CFG_W'(SPH_CAP)) begin
      sph_eff = CNT_W'(SPH_CAP);
    end else begin
      sph_eff = CNT_W'(reg_sph_r);
    end
    if (reg_hpd_r == '0) begin
      hpd_eff = HC_W'(1);
    end else if (reg_hpd_r > CFG_W'(HPD_CAP)) begin
      hpd_eff = HC_W'(HPD_CAP);
    end else begin
      hpd_eff = HC_W'(reg_hpd_r);
    end
    dpp_eff = (reg_dpp_r == '0) ? CFG_W'(1) : reg_dpp_r;
    n_eff   = NW'(sph_eff) * NW'(hpd_eff);
  end

  // Magnitudes, counter increments and end-of-window tests
  always_comb begin
    mag       = samp_v[SB-1] ? SB'(-samp_v) : SB'(samp_v);
    cnt_nxt   = samp_cnt_r + CNT_W'(1);
    habs      = hacc_r[HACC_W-1] ? HACC_W'(-hacc_r) : HACC_W'(hacc_r);
    dabs      = dacc_r[DACC_W-1] ? DACC_W'(-dacc_r) : DACC_W'(dacc_r);
    hour_inc  = {1'b0, hour_cnt_r} + (HC_W + 1)'(1);
    day_end_w = hour_inc >= {1'b0, hpd_eff};
    day_inc   = {1'b0, day_cnt_r} + (CFG_W + 1)'(1);
    day_wrap  = day_inc >= {1'b0, dpp_eff};
  end

  // Square root step: two radicand bits in, one root bit out
  always_comb begin
    rem_sh      = {sq_rem_r[ISQ_W-1:0], sq_d_r[D_W-1 -: 2]};
    trial       = {sq_root_r, 2'b01};
    sq_ge       = rem_sh >= trial;
    sq_rem_nxt  = sq_ge ? rem_sh - trial : rem_sh;
    sq_root_nxt = {sq_root_r[ISQ_W-2:0], sq_ge};
  end

  wmd_mul #(
    .A_W (A_W),
    .B_W (B_W),
    .P_W (P_W)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start_r),
    .a     (mul_a_r),
    .b     (mul_b_r),
    .stat  (mul_stat),
    .prod  (mul_prod)
  );

  wmd_div #(
    .DV_W (DV_W),
    .DS_W (DS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_dvd_r),
    .divisor  (div_dvs_r),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  // Sequencer, sums, counters and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
      reg_sph_r   <= CFG_W'(wmd_pkg::RST_SAMPLES_PER_HOUR);
      reg_hpd_r   <= CFG_W'(wmd_pkg::RST_HOURS_PER_DAY);
      reg_dpp_r   <= CFG_W'(wmd_pkg::RST_DAYS_PER_PERIOD);
      hacc_r      <= '0;
      dacc_r      <= '0;
      sqacc_r     <= '0;
      samp_cnt_r  <= '0;
      hour_cnt_r  <= '0;
      day_cnt_r   <= '0;
      hour_end_r  <= 1'b0;
    end else begin
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;

      // drop the result once it is taken
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      // register writes; unknown indexes are ignored
      if (cfg_valid) begin
        unique case (cfg_index)
          wmd_pkg::REG_SAMPLES_PER_HOUR: reg_sph_r <= cfg_data;
          wmd_pkg::REG_HOURS_PER_DAY:    reg_hpd_r <= cfg_data;
          wmd_pkg::REG_DAYS_PER_PERIOD:  reg_dpp_r <= cfg_data;
          default: ;
        endcase
      end

      unique case (state_r)
        // take a sample, update the sums, start squaring it
        ST_IDLE: begin
          if (in_valid) begin
            hacc_r      <= hacc_r + HACC_W'(samp_v);
            dacc_r      <= dacc_r + DACC_W'(samp_v);
            samp_cnt_r  <= cnt_nxt;
            hour_end_r  <= cnt_nxt >= sph_eff;
            mul_a_r     <= A_W'(mag);
            mul_b_r     <= B_W'(mag);
            mul_start_r <= 1'b1;
            state_r     <= ST_SQ;
          end
        end

        // add the square, divide the hour sum if the hour is complete
        ST_SQ: begin
          if (mul_stat.done) begin
            sqacc_r <= sqacc_r + SQ_W'(mul_prod);
            if (hour_end_r) begin
              div_dvd_r   <= DV_W'(habs);
              div_dvs_r   <= DS_W'(sph_eff);
              div_neg_r   <= hacc_r[HACC_W-1];
              div_start_r <= 1'b1;
              state_r     <= ST_HDIV;
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end

        // hour average ready; advance the hour, start day work at day end
        ST_HDIV: begin
          if (div_stat.done) begin
            res_day_r  <= day_cnt_r;
            res_hour_r <= IDX_W'(hour_cnt_r);
            res_havg_r <= sat_s(QX_W'(div_quo), div_neg_r);
            hacc_r     <= '0;
            samp_cnt_r <= '0;
            if (day_end_w) begin
              hour_cnt_r  <= '0;
              mul_a_r     <= A_W'(sqacc_r);
              mul_b_r     <= B_W'(n_eff);
              mul_start_r <= 1'b1;
              state_r     <= ST_NSQ;
            end else begin
              hour_cnt_r  <= hour_inc[HC_W-1:0];
              res_dend_r  <= 1'b0;
              res_dmean_r <= '0;
              res_dsd_r   <= '0;
              state_r     <= ST_OUT;
            end
          end
        end

        // N * sum of squares held; square the day sum next
        ST_NSQ: begin
          if (mul_stat.done) begin
            nsq_r       <= mul_prod;
            mul_a_r     <= A_W'(dabs);
            mul_b_r     <= B_W'(dabs);
            mul_start_r <= 1'b1;
            state_r     <= ST_SMSQ;
          end
        end

        // radicand, negative taken as zero
        ST_SMSQ: begin
          if (mul_stat.done) begin
            sq_d_r    <= (mul_prod <= nsq_r) ? D_W'(nsq_r - mul_prod) : '0;
            sq_rem_r  <= '0;
            sq_root_r <= '0;
            sq_cnt_r  <= '0;
            state_r   <= ST_SQRT;
          end
        end

        // square root, then divide it by N
        ST_SQRT: begin
          sq_d_r    <= sq_d_r << 2;
          sq_rem_r  <= sq_rem_nxt;
          sq_root_r <= sq_root_nxt;
          sq_cnt_r  <= sq_cnt_r + 1'b1;
          if (sq_cnt_r == SC_W'(ISQ_W - 1)) begin
            div_dvd_r   <= DV_W'(sq_root_nxt);
            div_dvs_r   <= n_eff;
            div_neg_r   <= 1'b0;
            div_start_r <= 1'b1;
            state_r     <= ST_SDDIV;
          end
        end

        // deviation ready; divide the day sum by N
        ST_SDDIV: begin
          if (div_stat.done) begin
            res_dsd_r   <= sat_u(QX_W'(div_quo));
            div_dvd_r   <= DV_W'(dabs);
            div_dvs_r   <= n_eff;
            div_neg_r   <= dacc_r[DACC_W-1];
            div_start_r <= 1'b1;
            state_r     <= ST_MDIV;
          end
        end

        // day mean ready; clear day sums and advance the day
        ST_MDIV: begin
          if (div_stat.done) begin
            res_dmean_r <= sat_s(QX_W'(div_quo), div_neg_r);
            res_dend_r  <= 1'b1;
            dacc_r      <= '0;
            sqacc_r     <= '0;
            day_cnt_r   <= day_wrap ? '0 : day_inc[CFG_W-1:0];
            state_r     <= ST_OUT;
          end
        end

        // hand the result to the output register once it is free
        ST_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_day_r   <= res_day_r;
            out_hour_r  <= res_hour_r;
            out_havg_r  <= res_havg_r;
            out_dend_r  <= res_dend_r;
            out_dmean_r <= res_dmean_r;
            out_dsd_r   <= res_dsd_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall         = (state_r != ST_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_day_index    = out_day_r;
  assign out_hour_index   = out_hour_r;
  assign out_hour_average = out_havg_r;
  assign out_day_end      = out_dend_r;
  assign out_day_mean     = out_dmean_r;
  assign out_day_sd       = out_dsd_r;

  // The shared units never overlap
  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_stat.busy && div_stat.busy))
    else $error("multiplier and divider busy together");

  // No sample is taken while arithmetic is in flight
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (mul_stat.busy || div_stat.busy) |-> in_stall)
    else $error("input open while a unit is busy");

  // A multiplier result only lands in a state waiting for it
  a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_stat.done |-> (state_r == ST_SQ || state_r == ST_NSQ || state_r == ST_SMSQ))
    else $error("multiplier done outside a multiply state");

  // Day fields stay zero on an ordinary hour
  a_day_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_day_end) |-> (out_day_mean == '0 && out_day_sd == '0))
    else $error("day fields set without day end");

  // Hour sample count is cleared when the sequencer returns to idle after an hour end
  a_count_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(state_r == ST_IDLE) && $past(hour_end_r)) |-> (samp_cnt_r == '0))
    else $error("hour sample count not cleared after hour end");

endmodule : window_mean_and_deviation

`default_nettype wire
